// File: hdl/lkvc_pkg.sv
`timescale 1ns / 1ps
package lkvc_pkg;

   localparam int ENTRIES_DEFAULT = 16;
   localparam int KEY_W           = 32;
   localparam int VALUE_W         = 32;
   localparam int CAP_W           = 5;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef struct packed {
      logic                      op;
      logic signed [KEY_W-1:0]   key;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                      hit;
      logic signed [VALUE_W-1:0] read_value;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_UPDATE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic capture;
      logic update;
   } ctrl_cmd_type;

   typedef struct packed {
      logic op;
   } ctrl_status_type;

endpackage

// File: hdl/lkvc_ram.sv
`timescale 1ns / 1ps
module lkvc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

// File: hdl/lkvc_ctrl.sv
`timescale 1ns / 1ps
module lkvc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  lkvc_pkg::ctrl_status_type status,
   output lkvc_pkg::ctrl_cmd_type  cmd,
   output logic                    busy,
   output logic                    rsp_strobe
);

   import lkvc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (status.op == OP_GET) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_MATCH: begin
            cmd.capture = 1'b1;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_RESP: begin
            rsp_strobe = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// File: hdl/lkvc_datapath.sv
`timescale 1ns / 1ps
module lkvc_datapath #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lkvc_pkg::req_type          req_item,
   input  logic                       csr_write_en,
   input  logic [lkvc_pkg::CAP_W-1:0] csr_write_data,
   input  lkvc_pkg::ctrl_cmd_type     cmd,
   output lkvc_pkg::ctrl_status_type  status,
   output lkvc_pkg::rsp_type          rsp_item
);

   import lkvc_pkg::*;

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int RANK_W = IDX_W;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

   req_type            req_ff;
   logic [CAP_W-1:0]   capacity_ff;
   logic [KEY_W-1:0]   key_ff [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;
   logic [RANK_W-1:0]  rank_ff [ENTRIES];
   logic [RANK_W-1:0]  rank_in [ENTRIES];
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   // lookup results held for the update step
   logic [ENTRIES-1:0] hit_vec_ff;
   logic [ENTRIES-1:0] hit_vec_in;
   logic               hit_ff;
   logic [IDX_W-1:0]   hit_idx_ff;
   logic [IDX_W-1:0]   hit_idx_in;
   logic [RANK_W-1:0]  hit_rank_ff;
   logic [RANK_W-1:0]  hit_rank_in;
   logic [IDX_W-1:0]   victim_idx_ff;
   logic [IDX_W-1:0]   victim_idx_in;
   logic [IDX_W-1:0]   free_idx_ff;
   logic [IDX_W-1:0]   free_idx_in;
   logic               evict_ff;
   logic               evict_in;

   logic [RANK_W-1:0]  last_rank;
   logic [CMP_W-1:0]   cap_ext;
   logic [CMP_W-1:0]   eff_cap;
   logic [IDX_W-1:0]   slot;
   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [VALUE_W-1:0] ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_write_en) begin
         capacity_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
   end

   // effective capacity, clamped to one .. ENTRIES
   always_comb begin
      cap_ext = CMP_W'(capacity_ff);
      eff_cap = cap_ext;
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end
   end

   assign last_rank = RANK_W'(count_ff - CNT_W'(1));

   always_comb begin
      hit_vec_in    = '0;
      hit_idx_in    = '0;
      hit_rank_in   = '0;
      victim_idx_in = '0;
      free_idx_in   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec_in[i] = valid_ff[i] && (key_ff[i] == req_ff.key);
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec_in[i]) begin
            hit_idx_in = IDX_W'(i);
         end
         if (valid_ff[i] && (rank_ff[i] == last_rank)) begin
            victim_idx_in = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_idx_in = IDX_W'(i);
         end
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit_vec_in[i]) begin
            hit_rank_in = hit_rank_in | rank_ff[i];
         end
      end
      evict_in = CMP_W'(count_ff) >= eff_cap;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         hit_vec_ff    <= hit_vec_in;
         hit_ff        <= |hit_vec_in;
         hit_idx_ff    <= hit_idx_in;
         hit_rank_ff   <= hit_rank_in;
         victim_idx_ff <= victim_idx_in;
         free_idx_ff   <= free_idx_in;
         evict_ff      <= evict_in;
      end
   end

   assign slot = evict_ff ? victim_idx_ff : free_idx_ff;

   always_comb begin
      valid_in  = valid_ff;
      rank_in   = rank_ff;
      count_in  = count_ff;
      ram_we    = 1'b0;
      ram_waddr = hit_idx_ff;
      if (cmd.update) begin
         if (hit_ff) begin
            // touch: more recent entries age by one
            for (int i = 0; i < ENTRIES; i++) begin
               if (hit_vec_ff[i]) begin
                  rank_in[i] = '0;
               end else if (valid_ff[i] && (rank_ff[i] < hit_rank_ff)) begin
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
               end
            end
            ram_we = (req_ff.op == OP_PUT);
         end else if (req_ff.op == OP_PUT) begin
            // insert, reusing the least recent slot when full
            ram_we    = 1'b1;
            ram_waddr = slot;
            for (int i = 0; i < ENTRIES; i++) begin
               if (IDX_W'(i) == slot) begin
                  rank_in[i]  = '0;
                  valid_in[i] = 1'b1;
               end else if (valid_ff[i]) begin
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
               end
            end
            if (!evict_ff) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rank_ff  <= '{default: '0};
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update && !hit_ff && (req_ff.op == OP_PUT)) begin
         key_ff[slot] <= req_ff.key;
      end
   end

   lkvc_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (ENTRIES)
   ) u_value_ram (
      .clock      (clock),
      .write_en   (ram_we),
      .write_addr (ram_waddr),
      .write_data (req_ff.value),
      .read_addr  (hit_idx_ff),
      .read_data  (ram_rdata)
   );

   assign status.op           = req_ff.op;
   assign rsp_item.hit        = hit_ff;
   assign rsp_item.read_value = hit_ff ? ram_rdata : '0;

endmodule

// File: hdl/lru_key_value_cache_unit.sv
`timescale 1ns / 1ps
// Fully associative key/value cache with least-recently-used replacement over ENTRIES
// slots. An item is taken when start is high and busy is low. A get returns one result
// on rsp_item, strobed by rsp_strobe for a single cycle in the result state after the
// update step; the receiver must take it then, as it cannot stall the block. A put
// returns nothing. An item holds the block busy through its steps in order: the
// registered compare of the key against every slot, the recency and slot update
// together with the read of the value memory, and on a get the presentation of the
// result. The capacity register resets to 16 and is clamped to the range one to
// ENTRIES; lowering it below the current fill keeps all entries, and each later insert
// then replaces the least recent one.
module lru_key_value_cache_unit #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  lkvc_pkg::req_type          req_item,
   output logic                       rsp_strobe,
   output lkvc_pkg::rsp_type          rsp_item,
   input  logic                       csr_write_en,
   input  logic [lkvc_pkg::CAP_W-1:0] csr_write_data
);

   import lkvc_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   lkvc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   lkvc_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_item       (req_item),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .status         (status),
      .rsp_item       (rsp_item)
   );

endmodule

// File: hdl/lkvc_checker.sv
`timescale 1ns / 1ps
module lkvc_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input lkvc_pkg::rsp_type rsp_item
);

   import lkvc_pkg::*;

   // a result only comes while an item is in hand
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> busy)
      else $error("result strobe while idle");

   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !busy)
      else $error("block not idle after result");

   // a miss carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.hit) |-> (rsp_item.read_value == '0))
      else $error("miss with non-zero value");

endmodule

bind lru_key_value_cache_unit lkvc_checker u_checker (.*);
